/* sv/qvr_pkg.sv */
// Shared constants for the quaternion vector rotation pipeline.
`default_nettype none

package qvr_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUAT_FRAC_DEF  = 30;
  localparam int PIPE_DEPTH     = 7;

endpackage

`default_nettype wire

/* sv/qvr_mul.sv */
// Two-stage signed multiplier that splits operand b into low and high partial products.
`default_nettype none

module qvr_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  wire logic                    clk,
  input  wire logic signed [WA-1:0]    a,
  input  wire logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0]      p
);

  localparam int L    = WB / 2;
  localparam int PW   = WA + WB;
  localparam int LOW  = WA + L + 1;
  localparam int HIW  = WA + WB - L;

  logic signed [L:0]      b_lo;
  logic signed [WB-L-1:0] b_hi;
  logic signed [LOW-1:0]  p_lo_r;
  logic signed [HIW-1:0]  p_hi_r;
  logic signed [PW-1:0]   p_nxt;
  logic signed [PW-1:0]   p_r;

  assign b_lo = $signed({1'b0, b[L-1:0]});
  assign b_hi = $signed(b[WB-1:L]);

  always_ff @(posedge clk) begin
    p_lo_r <= a * b_lo;
    p_hi_r <= a * b_hi;
  end

  assign p_nxt = $signed({p_hi_r, {L{1'b0}}}) + PW'(p_lo_r);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* sv/quaternion_vector_rotate.sv */
// Throughput: one transaction per cycle; busy is low whenever rst_n is high.
// Latency is two split multiplier banks of two stages each plus the t, r and output registers.
// Reset clears the valid pipeline; payload registers are not reset.
// Results cannot be stalled: out_valid marks each result for one cycle.
`default_nettype none

module quaternion_vector_rotate #(
  parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
  parameter int QUAT_FRAC  = qvr_pkg::QUAT_FRAC_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_z,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_rot_x,
  output logic signed [DATA_WIDTH-1:0]      out_rot_y,
  output logic signed [DATA_WIDTH-1:0]      out_rot_z,
  output logic                              out_clipped
);

  import qvr_pkg::*;

  localparam int D   = DATA_WIDTH;
  localparam int F   = QUAT_FRAC;
  localparam int PW1 = 2 * D;
  localparam int SW1 = (PW1 + 3 > F + 2) ? PW1 + 3 : F + 2;
  localparam int TW  = SW1 - F;
  localparam int PW2 = D + TW;
  localparam int SW2 = (PW2 + 3 > F + 2) ? PW2 + 3 : F + 2;
  localparam int RW  = SW2 - F;
  localparam int XW  = ((RW > D) ? RW : D) + 1;

  localparam logic signed [SW1-1:0] HALF1 = SW1'(1) << (F - 1);
  localparam logic signed [SW2-1:0] HALF2 = SW2'(1) << (F - 1);
  localparam logic [D-1:0] SAT_MAX = {1'b0, {(D-1){1'b1}}};
  localparam logic [D-1:0] SAT_MIN = {1'b1, {(D-1){1'b0}}};

  logic                      accept;
  logic [PIPE_DEPTH-2:0]     vld_r;
  logic [PIPE_DEPTH-2:0]     vld_nxt;
  logic                      out_valid_r;

  logic signed [D-1:0]   a1 [12];
  logic signed [D-1:0]   b1 [12];
  logic signed [PW1-1:0] p1 [12];
  logic signed [SW1-1:0] s1 [4];
  logic signed [TW-1:0]  t_r [4];

  logic signed [D-1:0]   qw_d_r [3];
  logic signed [D-1:0]   qx_d_r [3];
  logic signed [D-1:0]   qy_d_r [3];
  logic signed [D-1:0]   qz_d_r [3];

  logic signed [D-1:0]   a2 [12];
  logic signed [TW-1:0]  b2 [12];
  logic signed [PW2-1:0] p2 [12];
  logic signed [SW2-1:0] s2 [3];
  logic signed [RW-1:0]  r_r [3];
  logic signed [XW-1:0]  r_ext [3];
  logic [D-1:0]          sat_val [3];
  logic [2:0]            fits;

  logic [D-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic         clipped_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign vld_nxt = {vld_r[PIPE_DEPTH-3:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE_DEPTH-2];
    end
  end

  // t = q * (0, v)
  assign a1[0]  = in_quat_x; assign b1[0]  = in_vec_x;
  assign a1[1]  = in_quat_y; assign b1[1]  = in_vec_y;
  assign a1[2]  = in_quat_z; assign b1[2]  = in_vec_z;
  assign a1[3]  = in_quat_w; assign b1[3]  = in_vec_x;
  assign a1[4]  = in_quat_y; assign b1[4]  = in_vec_z;
  assign a1[5]  = in_quat_z; assign b1[5]  = in_vec_y;
  assign a1[6]  = in_quat_w; assign b1[6]  = in_vec_y;
  assign a1[7]  = in_quat_x; assign b1[7]  = in_vec_z;
  assign a1[8]  = in_quat_z; assign b1[8]  = in_vec_x;
  assign a1[9]  = in_quat_w; assign b1[9]  = in_vec_z;
  assign a1[10] = in_quat_x; assign b1[10] = in_vec_y;
  assign a1[11] = in_quat_y; assign b1[11] = in_vec_x;

  for (genvar i = 0; i < 12; i++) begin : g_mul1
    qvr_mul #(.WA(D), .WB(D)) u_mul (
      .clk (clk),
      .a   (a1[i]),
      .b   (b1[i]),
      .p   (p1[i])
    );
  end

  assign s1[0] = HALF1 - SW1'(p1[0]) - SW1'(p1[1])  - SW1'(p1[2]);
  assign s1[1] = HALF1 + SW1'(p1[3]) + SW1'(p1[4])  - SW1'(p1[5]);
  assign s1[2] = HALF1 + SW1'(p1[6]) - SW1'(p1[7])  + SW1'(p1[8]);
  assign s1[3] = HALF1 + SW1'(p1[9]) + SW1'(p1[10]) - SW1'(p1[11]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      t_r[k] <= s1[k][SW1-1:F];
    end
  end

  // hold q alongside the first multiplier bank and the t register
  always_ff @(posedge clk) begin
    qw_d_r[0] <= in_quat_w;
    qx_d_r[0] <= in_quat_x;
    qy_d_r[0] <= in_quat_y;
    qz_d_r[0] <= in_quat_z;
    for (int k = 1; k < 3; k++) begin
      qw_d_r[k] <= qw_d_r[k-1];
      qx_d_r[k] <= qx_d_r[k-1];
      qy_d_r[k] <= qy_d_r[k-1];
      qz_d_r[k] <= qz_d_r[k-1];
    end
  end

  // r = t * conj(q)
  assign a2[0]  = qx_d_r[2]; assign b2[0]  = t_r[0];
  assign a2[1]  = qw_d_r[2]; assign b2[1]  = t_r[1];
  assign a2[2]  = qz_d_r[2]; assign b2[2]  = t_r[2];
  assign a2[3]  = qy_d_r[2]; assign b2[3]  = t_r[3];
  assign a2[4]  = qy_d_r[2]; assign b2[4]  = t_r[0];
  assign a2[5]  = qz_d_r[2]; assign b2[5]  = t_r[1];
  assign a2[6]  = qw_d_r[2]; assign b2[6]  = t_r[2];
  assign a2[7]  = qx_d_r[2]; assign b2[7]  = t_r[3];
  assign a2[8]  = qz_d_r[2]; assign b2[8]  = t_r[0];
  assign a2[9]  = qy_d_r[2]; assign b2[9]  = t_r[1];
  assign a2[10] = qx_d_r[2]; assign b2[10] = t_r[2];
  assign a2[11] = qw_d_r[2]; assign b2[11] = t_r[3];

  for (genvar i = 0; i < 12; i++) begin : g_mul2
    qvr_mul #(.WA(D), .WB(TW)) u_mul (
      .clk (clk),
      .a   (a2[i]),
      .b   (b2[i]),
      .p   (p2[i])
    );
  end

  assign s2[0] = HALF2 - SW2'(p2[0]) + SW2'(p2[1])  - SW2'(p2[2])  + SW2'(p2[3]);
  assign s2[1] = HALF2 - SW2'(p2[4]) + SW2'(p2[5])  + SW2'(p2[6])  - SW2'(p2[7]);
  assign s2[2] = HALF2 - SW2'(p2[8]) - SW2'(p2[9])  + SW2'(p2[10]) + SW2'(p2[11]);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      r_r[k] <= s2[k][SW2-1:F];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_ext[k] = XW'(r_r[k]);
      fits[k]  = (r_ext[k][XW-1:D-1] == '0) || (r_ext[k][XW-1:D-1] == '1);
      if (fits[k]) begin
        sat_val[k] = r_ext[k][D-1:0];
      end else if (r_ext[k][XW-1]) begin
        sat_val[k] = SAT_MIN;
      end else begin
        sat_val[k] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    rot_x_r   <= sat_val[0];
    rot_y_r   <= sat_val[1];
    rot_z_r   <= sat_val[2];
    clipped_r <= ~(&fits);
  end

  assign out_valid   = out_valid_r;
  assign out_rot_x   = $signed(rot_x_r);
  assign out_rot_y   = $signed(rot_y_r);
  assign out_rot_z   = $signed(rot_z_r);
  assign out_clipped = clipped_r;

  a_valid_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without a matching transaction");

  a_source_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("transaction lost in pipeline");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (rot_x_r == SAT_MAX || rot_x_r == SAT_MIN ||
       rot_y_r == SAT_MAX || rot_y_r == SAT_MIN ||
       rot_z_r == SAT_MAX || rot_z_r == SAT_MIN))
    else $error("clip flag without a saturated component");

endmodule

`default_nettype wire

/* tb/tb_quaternion_vector_rotate.sv */
// Self-checking testbench for the quaternion vector rotation pipeline.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int QF = QUAT_FRAC_DEF;
  localparam int VEC_FRAC = 16;
  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_IDLE = 17;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t quat_w;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
  } quat_vec_t;

  typedef struct packed {
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
    logic  clipped;
  } rotation_t;

  typedef struct packed {
    quat_vec_t stim;
    logic      typed;
    rotation_t want;
  } directed_row_t;

  localparam word_t MAX_WORD = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MIN_WORD = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ONE_QUAT = word_t'(1) <<< QF;
  localparam word_t ONE_VEC  = word_t'(1) <<< VEC_FRAC;
  localparam wide_t HALF_LSB = 128'sd1 <<< (QF - 1);
  localparam wide_t WIDE_MAX = (128'sd1 <<< (DW - 1)) - 128'sd1;
  localparam wide_t WIDE_MIN = -(128'sd1 <<< (DW - 1));

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  word_t in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  word_t in_vec_x, in_vec_y, in_vec_z;
  logic  out_valid;
  word_t out_rot_x, out_rot_y, out_rot_z;
  logic  out_clipped;

  rotation_t     expected_rotations[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  int            rotations_checked = 0;
  int            saturated_seen = 0;
  int            random_sent = 0;

  quaternion_vector_rotate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .out_valid  (out_valid),
    .out_rot_x  (out_rot_x),
    .out_rot_y  (out_rot_y),
    .out_rot_z  (out_rot_z),
    .out_clipped(out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("%0t timeout with %0d rotations outstanding", $time, expected_rotations.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic wide_t round_fix(input wide_t acc);
    return (acc + HALF_LSB) >>> QF;
  endfunction

  function automatic bit out_of_range(input wide_t acc);
    return (acc > WIDE_MAX) || (acc < WIDE_MIN);
  endfunction

  function automatic word_t clamp_word(input wide_t acc);
    if (acc > WIDE_MAX) return MAX_WORD;
    if (acc < WIDE_MIN) return MIN_WORD;
    return acc[DW-1:0];
  endfunction

  function automatic rotation_t rotate_vector(input quat_vec_t item);
    wide_t qw, qx, qy, qz, vx, vy, vz;
    wide_t t0, t1, t2, t3, rx, ry, rz;
    rotation_t r;
    qw = $signed(item.quat_w);
    qx = $signed(item.quat_x);
    qy = $signed(item.quat_y);
    qz = $signed(item.quat_z);
    vx = $signed(item.vec_x);
    vy = $signed(item.vec_y);
    vz = $signed(item.vec_z);
    t0 = round_fix(-(qx * vx) - qy * vy - qz * vz);
    t1 = round_fix(qw * vx + qy * vz - qz * vy);
    t2 = round_fix(qw * vy - qx * vz + qz * vx);
    t3 = round_fix(qw * vz + qx * vy - qy * vx);
    rx = round_fix(-(t0 * qx) + t1 * qw - t2 * qz + t3 * qy);
    ry = round_fix(-(t0 * qy) + t1 * qz + t2 * qw - t3 * qx);
    rz = round_fix(-(t0 * qz) - t1 * qy + t2 * qx + t3 * qw);
    r.rot_x = clamp_word(rx);
    r.rot_y = clamp_word(ry);
    r.rot_z = clamp_word(rz);
    r.clipped = out_of_range(rx) || out_of_range(ry) || out_of_range(rz);
    return r;
  endfunction

  function automatic quat_vec_t make_item(input word_t w, x, y, z, vx, vy, vz);
    quat_vec_t item;
    item.quat_w = w;
    item.quat_x = x;
    item.quat_y = y;
    item.quat_z = z;
    item.vec_x = vx;
    item.vec_y = vy;
    item.vec_z = vz;
    return item;
  endfunction

  function automatic rotation_t make_rotation(input word_t x, y, z, input logic clip);
    rotation_t r;
    r.rot_x = x;
    r.rot_y = y;
    r.rot_z = z;
    r.clipped = clip;
    return r;
  endfunction

  task automatic add_row(input quat_vec_t stim, input logic typed, input rotation_t want);
    directed_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic word_t corner_word();
    case ($urandom_range(0, 6))
      0: return MAX_WORD;
      1: return MIN_WORD;
      2: return '0;
      3: return '1;
      4: return word_t'(1);
      5: return ONE_QUAT;
      default: return -ONE_QUAT;
    endcase
  endfunction

  function automatic word_t tie_word(input int shift);
    return word_t'($signed($urandom_range(0, 8)) - 4) <<< shift;
  endfunction

  function automatic quat_vec_t random_item();
    quat_vec_t item;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      item = make_item($signed($urandom) >>> 2, $signed($urandom) >>> 2,
                       $signed($urandom) >>> 2, $signed($urandom) >>> 2,
                       $signed($urandom) >>> 8, $signed($urandom) >>> 8,
                       $signed($urandom) >>> 8);
    end else if (kind < 65) begin
      item = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 80) begin
      item = make_item(corner_word(), corner_word(), corner_word(), corner_word(),
                       corner_word(), corner_word(), corner_word());
    end else begin
      item = make_item(tie_word(QF - 2), tie_word(QF - 2), tie_word(QF - 2), tie_word(QF - 2),
                       tie_word(0), tie_word(0), tie_word(0));
    end
    return item;
  endfunction

  task automatic drive_transaction(input quat_vec_t item, input rotation_t want,
                                   input int idle_cycles);
    if (idle_cycles > 0) begin
      start <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    in_quat_w <= item.quat_w;
    in_quat_x <= item.quat_x;
    in_quat_y <= item.quat_y;
    in_quat_z <= item.quat_z;
    in_vec_x <= item.vec_x;
    in_vec_y <= item.vec_y;
    in_vec_z <= item.vec_z;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_rotations.push_back(want);
  endtask

  task automatic check_field(input string field, input word_t want_v, input word_t got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t %s expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rotation_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_rotations.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result expected none actual %0d %0d %0d %0b",
                 $time, out_rot_x, out_rot_y, out_rot_z, out_clipped);
      end else begin
        want = expected_rotations.pop_front();
        rotations_checked++;
        if (want.clipped) saturated_seen++;
        check_field("rot_x", want.rot_x, out_rot_x);
        check_field("rot_y", want.rot_y, out_rot_y);
        check_field("rot_z", want.rot_z, out_rot_z);
        check_field("clipped", word_t'(want.clipped), word_t'(out_clipped));
      end
    end
  end

  initial begin
    quat_vec_t item;
    rotation_t want;
    int idle;
    int drain_cycles;
    bit burst;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_quat_w <= '0;
    in_quat_x <= '0;
    in_quat_y <= '0;
    in_quat_z <= '0;
    in_vec_x <= '0;
    in_vec_y <= '0;
    in_vec_z <= '0;

    add_row(make_item('0, '0, '0, '0, '0, '0, '0), 1'b1, make_rotation('0, '0, '0, 1'b0));
    add_row(make_item(ONE_QUAT, '0, '0, '0, ONE_VEC, 2 * ONE_VEC, -3 * ONE_VEC), 1'b1,
            make_rotation(ONE_VEC, 2 * ONE_VEC, -3 * ONE_VEC, 1'b0));
    add_row(make_item('0, '0, '0, '0, MAX_WORD, MIN_WORD, MAX_WORD), 1'b1,
            make_rotation('0, '0, '0, 1'b0));
    add_row(make_item(MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD, '0, '0, '0), 1'b1,
            make_rotation('0, '0, '0, 1'b0));
    add_row(make_item('0, ONE_QUAT, '0, '0, ONE_VEC, 2 * ONE_VEC, 3 * ONE_VEC), 1'b1,
            make_rotation(ONE_VEC, -2 * ONE_VEC, -3 * ONE_VEC, 1'b0));
    add_row(make_item(MIN_WORD, '0, '0, '0, MAX_WORD, MIN_WORD, 1), 1'b1,
            make_rotation(MAX_WORD, MIN_WORD, 4, 1'b1));
    add_row(make_item(ONE_QUAT >>> 1, '0, '0, '0, 1, -1, 3), 1'b1,
            make_rotation(1, '0, 1, 1'b0));
    add_row(make_item(MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD),
            1'b0, '0);
    add_row(make_item(MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD),
            1'b0, '0);
    add_row(make_item(MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD, MIN_WORD, MAX_WORD, MIN_WORD),
            1'b0, '0);
    add_row(make_item('1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
    add_row(make_item(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                      32'h55555555, 32'hAAAAAAAA, 32'h55555555), 1'b0, '0);
    add_row(make_item(32'h2D413CCD, '0, '0, 32'h2D413CCD, ONE_VEC, '0, '0), 1'b0, '0);
    add_row(make_item(ONE_QUAT >>> 1, ONE_QUAT >>> 1, ONE_QUAT >>> 1, ONE_QUAT >>> 1,
                      ONE_VEC, 2 * ONE_VEC, 3 * ONE_VEC), 1'b0, '0);
    add_row(make_item(ONE_QUAT, ONE_QUAT, ONE_QUAT, ONE_QUAT, 1, 1, -1), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      item = directed_rows[i].stim;
      want = directed_rows[i].typed ? directed_rows[i].want : rotate_vector(item);
      drive_transaction(item, want, $urandom_range(0, MAX_IDLE));
    end

    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      idle = burst ? 0 : $urandom_range(0, MAX_IDLE);
      item = random_item();
      drive_transaction(item, rotate_vector(item), idle);
      random_sent++;
    end
    start <= 1'b0;

    drain_cycles = 0;
    while (expected_rotations.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (expected_rotations.size() != 0) begin
      $display("%0t missing results expected %0d more actual 0", $time,
               expected_rotations.size());
      mismatches += expected_rotations.size();
    end

    $display("ran %0d directed and %0d random transactions with idle gaps of 0 to %0d cycles",
             directed_rows.size(), random_sent, MAX_IDLE);
    $display("checked %0d rotations, %0d of them saturated, %0d mismatches",
             rotations_checked, saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* quaternion_vector_rotate.f */
sv/qvr_pkg.sv
sv/qvr_mul.sv
sv/quaternion_vector_rotate.sv
tb/tb_quaternion_vector_rotate.sv
